// ----- hw/rtl/chained_hash_table_insert_core_macros.svh -----
// assertion macros for the chained hash table insert core
`ifndef CHAINED_HASH_TABLE_INSERT_CORE_MACROS_SVH
`define CHAINED_HASH_TABLE_INSERT_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cht_pkg.sv -----
// shared types, constants and microprogram of the chained hash table insert core
`default_nettype none

package cht_pkg;

  localparam int MAX_BUCKETS_DEF = 1024;
  localparam int SLOT_BYTES      = 3;
  localparam int TABLE_RATIO     = 3;

  localparam int FUNC_W   = 2;
  localparam int BUCKET_W = 10;
  localparam int OFF_W    = 24;
  localparam int SIDX_W   = 12;
  localparam int BC_W     = 11;
  localparam int USED_W   = 14;
  localparam int STATUS_W = 2;

  localparam logic [OFF_W-1:0] NAP        = 24'hFFFFFF;
  localparam logic [OFF_W-1:0] CHAIN_FLAG = 24'h800000;
  localparam int               CHAIN_BIT  = 23;

  // divide by three through a reciprocal, exact below 2^23
  localparam logic [23:0] DIV3_MUL   = 24'hAAAAAB;
  localparam int          DIV3_SHIFT = 25;
  localparam int          PROD_W     = 47;
  localparam int          QUOT_W     = PROD_W - DIV3_SHIFT;
  localparam int          IDX_W      = QUOT_W + 1;

  typedef enum logic [FUNC_W-1:0] {
    F_INSERT = 2'd0,
    F_READ   = 2'd1,
    F_CLEAR  = 2'd2,
    F_NONE   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OFF_BIG = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    U_IDLE,
    U_I0,
    U_I1,
    U_I2,
    U_I3,
    U_I4,
    U_W0,
    U_W1,
    U_W2,
    U_W3,
    U_WR_OFF,
    U_A0,
    U_A1,
    U_A2,
    U_R0,
    U_EMIT_RD,
    U_CLR_CMD,
    U_EMIT,
    U_CLR_RST
  } upc_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_OFF_BIG,
    C_BKT_OOR,
    C_RD_NAP,
    C_CUR_FULL,
    C_P_PLAIN,
    C_STEPS_OVER,
    C_IDX_OOR,
    C_CLR_LAST
  } cond_e;

  typedef enum logic [1:0] {
    RA_NONE,
    RA_BKT,
    RA_IDX,
    RA_SIDX
  } rdsel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLR,
    WR_OFF_LAST,
    WR_PTR_LAST,
    WR_P_NODE,
    WR_OFF_NODE1
  } wrsel_e;

  typedef struct packed {
    cond_e   cond;
    upc_e    tgt_t;
    upc_e    tgt_f;
    logic    dispatch;
    rdsel_e  rd_sel;
    wrsel_e  wr_sel;
    logic    ld_p;
    logic    st_set;
    status_e st_val;
    logic    steps_clr;
    logic    steps_inc;
    logic    mul_ld;
    logic    cur_inc;
    logic    cur_clr;
    logic    clr_step;
    logic    emit;
    logic    emit_rd;
  } cw_t;

  typedef struct packed {
    logic off_big;
    logic bkt_oor;
    logic rd_nap;
    logic cur_full;
    logic p_plain;
    logic steps_over;
    logic idx_oor;
    logic clr_last;
  } flags_t;

  function automatic cw_t ucode(input upc_e a);
    cw_t w;
    w          = '0;
    w.cond     = C_NEVER;
    w.tgt_t    = U_IDLE;
    w.tgt_f    = U_IDLE;
    w.rd_sel   = RA_NONE;
    w.wr_sel   = WR_NONE;
    w.st_val   = ST_OK;
    unique case (a)
      U_IDLE: begin
        w.dispatch = 1'b1;
      end
      U_I0: begin
        w.cond   = C_OFF_BIG;
        w.st_set = 1'b1;
        w.st_val = ST_OFF_BIG;
        w.tgt_t  = U_EMIT;
        w.tgt_f  = U_I1;
      end
      U_I1: begin
        w.rd_sel = RA_BKT;
        w.cond   = C_BKT_OOR;
        w.st_set = 1'b1;
        w.st_val = ST_FULL;
        w.tgt_t  = U_EMIT;
        w.tgt_f  = U_I2;
      end
      U_I2: begin
        w.ld_p  = 1'b1;
        w.cond  = C_RD_NAP;
        w.tgt_t = U_WR_OFF;
        w.tgt_f = U_I3;
      end
      U_I3: begin
        w.cond      = C_CUR_FULL;
        w.st_set    = 1'b1;
        w.st_val    = ST_FULL;
        w.steps_clr = 1'b1;
        w.tgt_t     = U_EMIT;
        w.tgt_f     = U_I4;
      end
      U_I4: begin
        w.cond  = C_P_PLAIN;
        w.tgt_t = U_A0;
        w.tgt_f = U_W0;
      end
      U_W0: begin
        w.cond      = C_STEPS_OVER;
        w.st_set    = 1'b1;
        w.st_val    = ST_FULL;
        w.mul_ld    = 1'b1;
        w.steps_inc = 1'b1;
        w.tgt_t     = U_EMIT;
        w.tgt_f     = U_W1;
      end
      U_W1: begin
        w.rd_sel = RA_IDX;
        w.cond   = C_IDX_OOR;
        w.st_set = 1'b1;
        w.st_val = ST_FULL;
        w.tgt_t  = U_EMIT;
        w.tgt_f  = U_W2;
      end
      U_W2: begin
        w.ld_p  = 1'b1;
        w.cond  = C_RD_NAP;
        w.tgt_t = U_WR_OFF;
        w.tgt_f = U_W3;
      end
      U_W3: begin
        w.cond  = C_P_PLAIN;
        w.tgt_t = U_A0;
        w.tgt_f = U_W0;
      end
      U_WR_OFF: begin
        w.wr_sel = WR_OFF_LAST;
        w.cond   = C_ALWAYS;
        w.tgt_t  = U_EMIT;
      end
      U_A0: begin
        w.wr_sel = WR_PTR_LAST;
        w.cond   = C_ALWAYS;
        w.tgt_t  = U_A1;
      end
      U_A1: begin
        w.wr_sel = WR_P_NODE;
        w.cond   = C_ALWAYS;
        w.tgt_t  = U_A2;
      end
      U_A2: begin
        w.wr_sel  = WR_OFF_NODE1;
        w.cur_inc = 1'b1;
        w.cond    = C_ALWAYS;
        w.tgt_t   = U_EMIT;
      end
      U_R0: begin
        w.rd_sel = RA_SIDX;
        w.cond   = C_ALWAYS;
        w.tgt_t  = U_EMIT_RD;
      end
      U_EMIT_RD: begin
        w.emit    = 1'b1;
        w.emit_rd = 1'b1;
      end
      U_CLR_CMD: begin
        w.wr_sel   = WR_CLR;
        w.clr_step = 1'b1;
        w.cur_clr  = 1'b1;
        w.cond     = C_CLR_LAST;
        w.tgt_t    = U_EMIT;
        w.tgt_f    = U_CLR_CMD;
      end
      U_EMIT: begin
        w.emit = 1'b1;
      end
      U_CLR_RST: begin
        w.wr_sel   = WR_CLR;
        w.clr_step = 1'b1;
        w.cur_clr  = 1'b1;
        w.cond     = C_CLR_LAST;
        w.tgt_t    = U_IDLE;
        w.tgt_f    = U_CLR_RST;
      end
      default: begin
        w.dispatch = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cht_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module cht_ram #(
  parameter int Width = 24,
  parameter int Depth = 3072,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cht_useq.sv -----
// microprogram sequencer: step counter, control rom and conditional jumps
`default_nettype none

module cht_useq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cht_pkg::FUNC_W-1:0]    func_i,
  input  cht_pkg::flags_t               flags_i,
  output cht_pkg::cw_t                  cw_o,
  output logic                          taken_o,
  output logic                          busy_o
);

  import cht_pkg::*;

  upc_e  upc_q, upc_d;
  upc_e  entry;
  cw_t   cw;
  logic  taken;
  func_e fsel;

  assign cw     = ucode(upc_q);
  assign cw_o   = cw;
  assign busy_o = (upc_q != U_IDLE);
  assign fsel   = func_e'(func_i);

  always_comb begin
    unique case (fsel)
      F_INSERT: entry = U_I0;
      F_READ:   entry = U_R0;
      F_CLEAR:  entry = U_CLR_CMD;
      F_NONE:   entry = U_EMIT;
      default:  entry = U_EMIT;
    endcase
  end

  always_comb begin
    unique case (cw.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_OFF_BIG:    taken = flags_i.off_big;
      C_BKT_OOR:    taken = flags_i.bkt_oor;
      C_RD_NAP:     taken = flags_i.rd_nap;
      C_CUR_FULL:   taken = flags_i.cur_full;
      C_P_PLAIN:    taken = flags_i.p_plain;
      C_STEPS_OVER: taken = flags_i.steps_over;
      C_IDX_OOR:    taken = flags_i.idx_oor;
      C_CLR_LAST:   taken = flags_i.clr_last;
      default:      taken = 1'b0;
    endcase
  end

  assign taken_o = taken;

  always_comb begin
    if (cw.dispatch && start_i) begin
      upc_d = entry;
    end else if (taken) begin
      upc_d = cw.tgt_t;
    end else begin
      upc_d = cw.tgt_f;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_CLR_RST;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cht_dp.sv -----
// datapath: operand registers, slot table ram, divide by three, cursor and result words
`default_nettype none

module cht_dp #(
  parameter int MaxBuckets = cht_pkg::MAX_BUCKETS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [cht_pkg::BUCKET_W-1:0]   bucket_i,
  input  logic [cht_pkg::OFF_W-1:0]      record_offset_i,
  input  logic [cht_pkg::SIDX_W-1:0]     slot_index_i,
  input  logic                           cfg_we_i,
  input  logic [cht_pkg::BC_W-1:0]       cfg_data_i,
  input  cht_pkg::cw_t                   cw_i,
  input  logic                           taken_i,
  output cht_pkg::flags_t                flags_o,
  output logic                           done_o,
  output logic [cht_pkg::OFF_W-1:0]      read_data_o,
  output logic [cht_pkg::STATUS_W-1:0]   status_o,
  output logic [cht_pkg::USED_W-1:0]     used_bytes_o
);

  import cht_pkg::*;

  localparam int TableSlots = TABLE_RATIO * MaxBuckets;
  localparam int SlotW      = $clog2(TableSlots);
  localparam int CurW       = $clog2(MaxBuckets + 1);
  localparam int StepW      = $clog2(TableSlots + 1);
  localparam int ByteW      = SlotW + 2;

  // operand words
  logic [BUCKET_W-1:0] bkt_q;
  logic [OFF_W-1:0]    off_q;
  logic [SIDX_W-1:0]   sidx_q;

  // walk state
  logic [OFF_W-1:0]  p_q;
  logic [PROD_W-1:0] prod_q;
  logic [SlotW-1:0]  last_q;
  logic [StepW-1:0]  steps_q;

  // table state
  logic [CurW-1:0]  cur_q;
  logic [CurW-1:0]  hl_q, hl_d;
  logic [SlotW-1:0] clr_q;
  status_e          st_q;

  // result words
  logic             done_q;
  logic [OFF_W-1:0] rd_out_q;
  status_e          st_out_q;
  logic [USED_W-1:0] used_out_q;

  logic [IDX_W-1:0] idx;
  logic [SlotW-1:0] nslot, nslot1;
  logic [ByteW-1:0] base3;
  logic [OFF_W-1:0] ptr;
  logic             sidx_oor;

  logic             ram_we, ram_re;
  logic [SlotW-1:0] ram_waddr, ram_raddr;
  logic [OFF_W-1:0] ram_wdata, ram_rdata;

  assign idx    = {1'b0, prod_q[PROD_W-1:DIV3_SHIFT]} + IDX_W'(1);
  assign nslot  = SlotW'(hl_q) + SlotW'({cur_q, 1'b0});
  assign nslot1 = nslot + SlotW'(1);
  assign base3  = ByteW'(nslot) * ByteW'(SLOT_BYTES);
  assign ptr    = OFF_W'(base3) | CHAIN_FLAG;

  assign sidx_oor = (32'(sidx_q) >= TableSlots);

  assign flags_o.off_big    = off_q[CHAIN_BIT];
  assign flags_o.bkt_oor    = (32'(bkt_q) >= TableSlots);
  assign flags_o.rd_nap     = (ram_rdata == NAP);
  assign flags_o.cur_full   = (cur_q >= hl_q);
  assign flags_o.p_plain    = !p_q[CHAIN_BIT];
  assign flags_o.steps_over = (32'(steps_q) >= TableSlots);
  assign flags_o.idx_oor    = (32'(idx) >= TableSlots);
  assign flags_o.clr_last   = (clr_q == SlotW'(TableSlots - 1));

  // effective bucket count
  always_comb begin
    if (cfg_data_i == '0) begin
      hl_d = CurW'(1);
    end else if (32'(cfg_data_i) > MaxBuckets) begin
      hl_d = CurW'(MaxBuckets);
    end else begin
      hl_d = CurW'(cfg_data_i);
    end
  end

  always_comb begin
    ram_re    = 1'b1;
    ram_raddr = SlotW'(bkt_q);
    unique case (cw_i.rd_sel)
      RA_NONE: ram_re    = 1'b0;
      RA_BKT:  ram_raddr = SlotW'(bkt_q);
      RA_IDX:  ram_raddr = SlotW'(idx);
      RA_SIDX: ram_raddr = SlotW'(sidx_q);
      default: ram_re    = 1'b0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = last_q;
    ram_wdata = off_q;
    unique case (cw_i.wr_sel)
      WR_NONE: ram_we = 1'b0;
      WR_CLR: begin
        ram_waddr = clr_q;
        ram_wdata = NAP;
      end
      WR_OFF_LAST: begin
        ram_waddr = last_q;
        ram_wdata = off_q;
      end
      WR_PTR_LAST: begin
        ram_waddr = last_q;
        ram_wdata = ptr;
      end
      WR_P_NODE: begin
        ram_waddr = nslot;
        ram_wdata = p_q;
      end
      WR_OFF_NODE1: begin
        ram_waddr = nslot1;
        ram_wdata = off_q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  cht_ram #(
    .Width (OFF_W),
    .Depth (TableSlots)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      hl_q    <= CurW'(1);
      clr_q   <= '0;
      st_q    <= ST_OK;
      steps_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hl_q <= hl_d;
      end
      if (cw_i.cur_clr) begin
        cur_q <= '0;
      end else if (cw_i.cur_inc) begin
        cur_q <= cur_q + CurW'(1);
      end
      if (cw_i.clr_step) begin
        clr_q <= flags_o.clr_last ? '0 : clr_q + SlotW'(1);
      end
      if (accept_i) begin
        st_q <= ST_OK;
      end else if (cw_i.st_set && taken_i) begin
        st_q <= cw_i.st_val;
      end
      if (cw_i.steps_clr) begin
        steps_q <= '0;
      end else if (cw_i.steps_inc) begin
        steps_q <= steps_q + StepW'(1);
      end
      done_q <= cw_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      bkt_q  <= bucket_i;
      off_q  <= record_offset_i;
      sidx_q <= slot_index_i;
    end
    if (cw_i.ld_p) begin
      p_q <= ram_rdata;
    end
    if (cw_i.mul_ld) begin
      prod_q <= PROD_W'(p_q[CHAIN_BIT-1:0]) * PROD_W'(DIV3_MUL);
    end
    if (cw_i.rd_sel == RA_BKT || cw_i.rd_sel == RA_IDX) begin
      last_q <= ram_raddr;
    end
    if (cw_i.emit) begin
      if (cw_i.emit_rd) begin
        rd_out_q <= sidx_oor ? NAP : ram_rdata;
      end else begin
        rd_out_q <= '0;
      end
      st_out_q   <= st_q;
      used_out_q <= USED_W'(base3);
    end
  end

  assign done_o       = done_q;
  assign read_data_o  = rd_out_q;
  assign status_o     = st_out_q;
  assign used_bytes_o = used_out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/chained_hash_table_insert_core.sv -----
// top level of the chained hash table insert core
//
// command port: func_i with bucket_i, record_offset_i and slot_index_i is taken
// at a rising edge with start_i high and busy_o low. each command gives one
// result word, shown for one cycle with done_o high; the receiver cannot stall.
// cfg_we_i writes cfg_data_i into the bucket count register; write only while idle.
// a zero is stored as 1 and a value above MAX_BUCKETS as MAX_BUCKETS.
// a clear sweeps the slot table one slot a cycle. an insert rejects an oversize
// offset, stores into an empty bucket directly, is rejected when the chain area is
// full, and otherwise walks any chain and links a new node at its end; it is also
// rejected when a bad chain is found.
// the control program runs one step a cycle, and each chain hop is a ram read
// with registered data plus a divide by three.
// busy_o drops in the cycle the result is shown, so a new command may follow
// at once; no new command is taken while one is in progress.
// after reset the slot table is swept to empty, one slot at a time, with
// busy_o high; configuration writes are still taken during the sweep.
`default_nettype none

module chained_hash_table_insert_core #(
  parameter int MAX_BUCKETS = cht_pkg::MAX_BUCKETS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [cht_pkg::FUNC_W-1:0]     func_i,
  input  logic [cht_pkg::BUCKET_W-1:0]   bucket_i,
  input  logic [cht_pkg::OFF_W-1:0]      record_offset_i,
  input  logic [cht_pkg::SIDX_W-1:0]     slot_index_i,
  input  logic                           cfg_we_i,
  input  logic [cht_pkg::BC_W-1:0]       cfg_data_i,
  output logic                           done_o,
  output logic [cht_pkg::OFF_W-1:0]      read_data_o,
  output logic [cht_pkg::STATUS_W-1:0]   status_o,
  output logic [cht_pkg::USED_W-1:0]     used_bytes_o
);

  import cht_pkg::*;

  cw_t    cw;
  flags_t flags;
  logic   taken;
  logic   busy;
  logic   accept;

  assign accept = start_i && !busy;
  assign busy_o = busy;

  cht_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (func_i),
    .flags_i (flags),
    .cw_o    (cw),
    .taken_o (taken),
    .busy_o  (busy)
  );

  cht_dp #(
    .MaxBuckets (MAX_BUCKETS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .bucket_i        (bucket_i),
    .record_offset_i (record_offset_i),
    .slot_index_i    (slot_index_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .cw_i            (cw),
    .taken_i         (taken),
    .flags_o         (flags),
    .done_o          (done_o),
    .read_data_o     (read_data_o),
    .status_o        (status_o),
    .used_bytes_o    (used_bytes_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/cht_checker.sv -----
// port-level checker for the chained hash table insert core, with its bind
`default_nettype none
`include "chained_hash_table_insert_core_macros.svh"

module cht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [23:0] read_data_o
);

  import cht_pkg::*;

  `CHT_ASSERT_NEXT(a_busy_after_accept, start_i && !busy_o, busy_o, "not busy after accept")
  `CHT_ASSERT_SAME(a_idle_on_done, done_o, !busy_o, "busy while result shown")
  `CHT_ASSERT_NEXT(a_single_word, done_o, !done_o, "result words back to back")
  `CHT_ASSERT_SAME(a_status_code, done_o, status_o <= ST_FULL, "unknown status code")
  `CHT_ASSERT_SAME(a_err_no_data, done_o && status_o != ST_OK, read_data_o == 24'd0,
                   "data on failed command")

endmodule

bind chained_hash_table_insert_core cht_checker u_cht_checker (.*);

`default_nettype wire

// ----- verif/tb_chained_hash_table_insert_core.sv -----
// self-checking testbench for the chained hash table insert core, with its own table predictor
`default_nettype none

module tb_chained_hash_table_insert_core;
  import cht_pkg::*;

  localparam int TABLE_SLOTS = TABLE_RATIO * MAX_BUCKETS_DEF;
  localparam logic [OFF_W-1:0] OFF_LIMIT = 24'h800000;

  typedef struct {
    func_e               func;
    logic [BUCKET_W-1:0] bucket;
    logic [OFF_W-1:0]    offset;
    logic [SIDX_W-1:0]   sidx;
  } hash_cmd_t;

  typedef struct {
    logic [OFF_W-1:0]  rd;
    status_e           st;
    logic [USED_W-1:0] used;
  } hash_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [FUNC_W-1:0]   func_i;
  logic [BUCKET_W-1:0] bucket_i;
  logic [OFF_W-1:0]    record_offset_i;
  logic [SIDX_W-1:0]   slot_index_i;
  logic                cfg_we_i;
  logic [BC_W-1:0]     cfg_data_i;
  logic                done_o;
  logic [OFF_W-1:0]    read_data_o;
  logic [STATUS_W-1:0] status_o;
  logic [USED_W-1:0]   used_bytes_o;

  chained_hash_table_insert_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .bucket_i       (bucket_i),
    .record_offset_i(record_offset_i),
    .slot_index_i   (slot_index_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .read_data_o    (read_data_o),
    .status_o       (status_o),
    .used_bytes_o   (used_bytes_o)
  );

  logic [OFF_W-1:0] shadow_slots [TABLE_SLOTS];
  int unsigned      shadow_nodes;
  logic [BC_W-1:0]  shadow_buckets;

  hash_cmd_t    cmd_feed[$];
  hash_result_t due_results[$];
  hash_result_t want;
  hash_cmd_t    seen_cmd;
  hash_cmd_t    next_cmd;

  int unsigned pushed;
  int unsigned acc_cnt;
  int unsigned res_cnt;
  int unsigned shown_at;
  int unsigned err_cnt;
  int unsigned n_insert, n_read, n_clear, n_full, n_big, n_settings;
  bit          steady;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int unsigned live_buckets();
    if (shadow_buckets == 0) return 1;
    if (shadow_buckets > MAX_BUCKETS_DEF) return MAX_BUCKETS_DEF;
    return 32'(shadow_buckets);
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < TABLE_SLOTS; i++) shadow_slots[i] = NAP;
    shadow_nodes = 0;
  endfunction

  function automatic status_e link_offset(logic [BUCKET_W-1:0] bkt, logic [OFF_W-1:0] off);
    int unsigned      hl;
    int unsigned      last;
    int unsigned      steps;
    int unsigned      idx;
    int unsigned      nslot;
    logic [OFF_W-1:0] p;
    hl = live_buckets();
    if (off >= OFF_LIMIT) return ST_OFF_BIG;
    last = 32'(bkt);
    p = shadow_slots[last];
    if (p == NAP) begin
      shadow_slots[last] = off;
      return ST_OK;
    end
    if (shadow_nodes >= hl) return ST_FULL;
    if (p[CHAIN_BIT]) begin
      steps = 0;
      while (1'b1) begin
        if (steps >= TABLE_SLOTS) return ST_FULL;
        idx = int'(p[CHAIN_BIT-1:0]) / SLOT_BYTES + 1;
        if (idx >= TABLE_SLOTS) return ST_FULL;
        last = idx;
        p = shadow_slots[idx];
        if (p == NAP) begin
          shadow_slots[idx] = off;
          return ST_OK;
        end
        if (!p[CHAIN_BIT]) break;
        steps++;
      end
    end
    nslot = hl + 2 * shadow_nodes;
    shadow_slots[last] = OFF_W'(nslot * SLOT_BYTES) | CHAIN_FLAG;
    shadow_slots[nslot] = p;
    shadow_slots[nslot + 1] = off;
    shadow_nodes++;
    return ST_OK;
  endfunction

  function automatic hash_result_t predict_result(hash_cmd_t c);
    hash_result_t r;
    r.rd = '0;
    r.st = ST_OK;
    case (c.func)
      F_INSERT: r.st = link_offset(c.bucket, c.offset);
      F_READ:   r.rd = (c.sidx < TABLE_SLOTS) ? shadow_slots[c.sidx] : NAP;
      F_CLEAR:  wipe_table();
      default:  ;
    endcase
    r.used = USED_W'((live_buckets() + 2 * shadow_nodes) * SLOT_BYTES);
    return r;
  endfunction

  task automatic flag_bad(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_cnt++;
  endtask

  // word accepted on start and not busy; result taken on done
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (done_o === 1'b1) begin
        res_cnt++;
        if (due_results.size() == 0) begin
          flag_bad("result word with nothing pending");
        end else begin
          want = due_results.pop_front();
          if (read_data_o !== want.rd)
            flag_bad($sformatf("read_data %h, predicted %h", read_data_o, want.rd));
          if (status_o !== want.st)
            flag_bad($sformatf("status %0d, predicted %0d", status_o, want.st));
          if (used_bytes_o !== want.used)
            flag_bad($sformatf("used_bytes %0d, predicted %0d", used_bytes_o, want.used));
        end
      end
      if (start_i && busy_o === 1'b0) begin
        seen_cmd.func   = func_e'(func_i);
        seen_cmd.bucket = bucket_i;
        seen_cmd.offset = record_offset_i;
        seen_cmd.sidx   = slot_index_i;
        want = predict_result(seen_cmd);
        due_results.push_back(want);
        acc_cnt++;
        case (seen_cmd.func)
          F_INSERT: n_insert++;
          F_READ:   n_read++;
          F_CLEAR:  n_clear++;
          default:  ;
        endcase
        if (want.st == ST_FULL) n_full++;
        if (want.st == ST_OFF_BIG) n_big++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (start_i && acc_cnt == shown_at) begin
      // still waiting for the word to be taken
    end else if (cmd_feed.size() != 0 && (steady || $urandom_range(99, 0) >= 37)) begin
      next_cmd = cmd_feed.pop_front();
      start_i         <= 1'b1;
      func_i          <= next_cmd.func;
      bucket_i        <= next_cmd.bucket;
      record_offset_i <= next_cmd.offset;
      slot_index_i    <= next_cmd.sidx;
      shown_at = acc_cnt;
    end else begin
      start_i <= 1'b0;
    end
  end

  task automatic queue_cmd(input func_e f, input int unsigned b, input int unsigned o,
                           input int unsigned s);
    hash_cmd_t c;
    c.func   = f;
    c.bucket = BUCKET_W'(b);
    c.offset = OFF_W'(o);
    c.sidx   = SIDX_W'(s);
    cmd_feed.push_back(c);
    pushed++;
  endtask

  task automatic queue_random(input int unsigned hl);
    int unsigned r;
    int unsigned hot;
    int unsigned b;
    int unsigned o;
    int unsigned s;
    func_e       f;
    r   = $urandom_range(999, 0);
    hot = (hl < 16) ? hl : 16;
    b   = $urandom_range(MAX_BUCKETS_DEF - 1, 0);
    o   = $urandom_range(24'hFFFFFF, 0);
    s   = $urandom_range(4095, 0);
    if (r < 15) begin
      f = F_CLEAR;
    end else if (r < 45) begin
      f = F_NONE;
    end else if (r < 260) begin
      f = F_READ;
      if ($urandom_range(9, 0) < 7) s = $urandom_range(3 * hl - 1, 0);
    end else begin
      f = F_INSERT;
      r = $urandom_range(99, 0);
      if (r < 6) o = $urandom_range(24'hFFFFFF, 24'h800000);
      else if (r < 8) o = 0;
      else if (r < 10) o = 24'h7FFFFF;
      else o = $urandom_range(24'h7FFFFF, 0);
      r = $urandom_range(99, 0);
      if (r < 45) b = $urandom_range(hot - 1, 0);
      else if (r >= 53) b = $urandom_range(hl - 1, 0);
    end
    queue_cmd(f, b, o, s);
  endtask

  task automatic drain();
    while (res_cnt < pushed) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_buckets(input logic [BC_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_buckets = v;
    n_settings++;
  endtask

  task automatic run_phase(input logic [BC_W-1:0] v, input int unsigned n,
                           input bit wipe_first, input bit gapless);
    drain();
    set_buckets(v);
    steady = gapless;
    @(posedge clk_i);
    if (wipe_first) queue_cmd(F_CLEAR, 0, 0, 0);
    repeat (n) queue_random(live_buckets());
  endtask

  initial begin
    #(12 * 6_000_000);
    $display("timeout waiting for result words");
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    func_i          = F_NONE;
    bucket_i        = '0;
    record_offset_i = '0;
    slot_index_i    = '0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = '0;
    steady          = 1'b0;
    wipe_table();
    shadow_buckets = BC_W'(1);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single bucket: fill, chain once, then overflow and oversize cases
    queue_cmd(F_INSERT, 0, 0, 0);
    queue_cmd(F_INSERT, 0, 24'h7FFFFF, 0);
    queue_cmd(F_INSERT, 0, 5, 0);
    queue_cmd(F_INSERT, 0, 24'h800000, 0);
    queue_cmd(F_INSERT, 1023, 24'hFFFFFF, 4095);
    queue_cmd(F_INSERT, 1023, 24'h123456, 0);
    queue_cmd(F_INSERT, 1023, 9, 0);
    queue_cmd(F_READ, 0, 0, 0);
    queue_cmd(F_READ, 0, 0, 1);
    queue_cmd(F_READ, 0, 0, 2);
    queue_cmd(F_READ, 0, 0, 1023);
    queue_cmd(F_READ, 0, 0, 3071);
    queue_cmd(F_READ, 0, 0, 3072);
    queue_cmd(F_READ, 1023, 24'hFFFFFF, 4095);
    queue_cmd(F_NONE, 1023, 24'hFFFFFF, 4095);
    queue_cmd(F_CLEAR, 0, 0, 0);
    queue_cmd(F_READ, 0, 0, 0);
    drain();

    // three buckets: walk a chain of two nodes
    set_buckets(3);
    @(posedge clk_i);
    queue_cmd(F_INSERT, 1, 1, 0);
    queue_cmd(F_INSERT, 1, 2, 0);
    queue_cmd(F_INSERT, 1, 3, 0);
    queue_cmd(F_INSERT, 1, 4, 0);
    queue_cmd(F_READ, 0, 0, 1);
    queue_cmd(F_READ, 0, 0, 4);
    queue_cmd(F_READ, 0, 0, 6);

    run_phase(11'd2047, 160, 1'b1, 1'b0);
    run_phase(11'd4, 110, 1'b1, 1'b0);
    run_phase(11'd0, 40, 1'b1, 1'b0);
    run_phase(11'd1024, 200, 1'b1, 1'b1);
    run_phase(11'($urandom_range(200, 5)), 25, 1'b0, 1'b0);
    run_phase(11'($urandom_range(1024, 1)), 120, 1'b1, 1'b0);
    run_phase(11'd1, 60, 1'b1, 1'b0);
    run_phase(11'd16, 200, 1'b1, 1'b0);
    drain();
    repeat (16) @(posedge clk_i);

    if (due_results.size() != 0)
      flag_bad($sformatf("%0d predicted words never arrived", due_results.size()));
    $display("ran %0d commands over %0d bucket settings: %0d inserts, %0d reads, %0d clears",
             acc_cnt, n_settings, n_insert, n_read, n_clear);
    $display("rejected inserts: %0d with chain area full, %0d with oversize offset",
             n_full, n_big);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
